// ===== rtl/rrn_pkg.sv =====
// ----------------------------------------------------------------------------
// rrn_pkg : shared constants for the running range normaliser
// Default parameter values and fixed field widths.
// ----------------------------------------------------------------------------
package rrn_pkg;

	localparam int NUM_CHANNELS_DEF = 8;
	localparam int SAMPLE_BITS_DEF  = 18;

	localparam int CHANNEL_W  = 3;
	localparam int SAMPLE_W   = 18;
	localparam int FRAC_BITS  = 16;
	localparam int FRACTION_W = FRAC_BITS + 1;

endpackage

// ===== rtl/running_range_normalizer_unit.sv =====
// ----------------------------------------------------------------------------
// running_range_normalizer_unit : per-channel min/max tracking and Q1.16 scaling
// Steps: 1 store update, 17 restoring-divider steps, 1 output load; a zero range
//   or bad channel skips the divider steps.
// Beats: accepted only in idle, after the last result is loaded; the next beat is taken
//   while a result waits, and the output load stalls until that result is taken.
// Reset: asynchronous, clears control state; lowest to all ones, highest to zero.
// ----------------------------------------------------------------------------
module running_range_normalizer_unit #(
	parameter int NUM_CHANNELS = rrn_pkg::NUM_CHANNELS_DEF,
	parameter int SAMPLE_BITS  = rrn_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [rrn_pkg::CHANNEL_W-1:0]   channel,
	input  logic [rrn_pkg::SAMPLE_W-1:0]    sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [rrn_pkg::FRACTION_W-1:0]  fraction,
	output logic                            range_empty
);
	import rrn_pkg::*;

	localparam int IDXW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CEXTW = IDXW + CHANNEL_W;
	localparam int STEPS = FRAC_BITS + 1;
	localparam int CNTW  = $clog2(STEPS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_PUT  = 2'd3;

	logic [1:0]             state_q;
	logic [CHANNEL_W-1:0]   ch_q;
	logic [SAMPLE_BITS-1:0] samp_q;
	logic [SAMPLE_BITS-1:0] lowest_q  [NUM_CHANNELS];
	logic [SAMPLE_BITS-1:0] highest_q [NUM_CHANNELS];
	logic [SAMPLE_BITS:0]   rem_q;
	logic [SAMPLE_BITS-1:0] span_q;
	logic [FRACTION_W-1:0]  quot_q;
	logic [CNTW-1:0]        cnt_q;
	logic                   empty_q;
	logic                   out_valid_q;
	logic [FRACTION_W-1:0]  fraction_q;
	logic                   range_empty_q;

	logic [SAMPLE_W+SAMPLE_BITS-1:0] samp_ext;
	logic [CEXTW-1:0]                ch_ext;
	logic [IDXW-1:0]                 idx;
	logic                            ch_ok;
	logic [SAMPLE_BITS-1:0]          lo_n, hi_n;
	logic [SAMPLE_BITS:0]            trial, rem_n;
	logic                            ge;
	logic                            load_out;

	assign samp_ext = {{SAMPLE_BITS{1'b0}}, sample};
	assign ch_ext   = {{IDXW{1'b0}}, ch_q};
	assign idx      = ch_ext[IDXW-1:0];
	assign ch_ok    = ch_ext < CEXTW'(NUM_CHANNELS);

	always_comb begin
		lo_n = lowest_q[idx];
		hi_n = highest_q[idx];
		if (samp_q < lo_n) begin
			lo_n = samp_q;
		end
		if (samp_q > hi_n) begin
			hi_n = samp_q;
		end
	end

	// shared subtract/compare, one quotient bit a step
	always_comb begin
		if (cnt_q == '0) begin
			trial = rem_q;
		end else begin
			trial = {rem_q[SAMPLE_BITS-1:0], 1'b0};
		end
		ge    = trial >= {1'b0, span_q};
		rem_n = ge ? trial - {1'b0, span_q} : trial;
	end

	assign in_ready = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_PUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				lowest_q[i]  <= '1;
				highest_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q <= '0;
					if (ch_ok) begin
						lowest_q[idx]  <= lo_n;
						highest_q[idx] <= hi_n;
					end
					if (!ch_ok || hi_n <= lo_n) begin
						state_q <= ST_PUT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNTW'(1);
					if (cnt_q == CNTW'(STEPS - 1)) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_q   <= channel;
			samp_q <= samp_ext[SAMPLE_BITS-1:0];
		end
		if (state_q == ST_LOAD) begin
			empty_q <= !ch_ok || (hi_n <= lo_n);
			rem_q   <= {1'b0, samp_q - lo_n};
			span_q  <= hi_n - lo_n;
			quot_q  <= '0;
		end
		if (state_q == ST_DIV) begin
			rem_q  <= rem_n;
			quot_q <= {quot_q[FRACTION_W-2:0], ge};
		end
		if (load_out) begin
			fraction_q    <= empty_q ? '0 : quot_q;
			range_empty_q <= empty_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign fraction    = fraction_q;
	assign range_empty = range_empty_q;

endmodule
